@@ design/wmm_pkg.sv @@
`timescale 1ns / 1ps

package wmm_pkg;

   localparam int unsigned SAMPLE_W   = 32;
   localparam int unsigned LEN_W      = 9;
   localparam int unsigned SUM_W      = SAMPLE_W + LEN_W;
   localparam int unsigned STEP_W     = $clog2(SUM_W + 1);
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [SUM_W-1:0]    sum_type;

   localparam logic    REG_WINDOW_LENGTH   = 1'b0;
   localparam len_type WINDOW_LENGTH_RESET = 9'd256;

endpackage

@@ design/windowed_min_max_mean.sv @@
`timescale 1ns / 1ps

// Sliding-window minimum, maximum and truncated mean over unsigned Q16.16 samples.
// Each accepted sample is written into a ring memory of MAX_DEPTH entries and
// produces one result transaction covering the most recent samples, at most
// window_length of them (0 acts as 1, values above min(MAX_DEPTH,511) clamp to it).
// One sample is processed at a time: a transaction runs from acceptance
// through a scan of the window by the single memory read port, one entry
// per cycle, and through the bit-serial divider that forms the mean (41
// steps); the next sample can be accepted once the result has been loaded
// into the output register. The result sits in that output register, so
// the next sample is accepted while a finished result still waits to be
// taken.
// window_length is at byte address 0 of the register port and should be
// changed only while the block is idle; the memory needs no clearing after
// reset, since only entries written since reset are ever read.
module windowed_min_max_mean
   import wmm_pkg::*;
#(
   parameter int unsigned MAX_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [SAMPLE_W-1:0]   req_sample,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [SAMPLE_W-1:0]   rsp_min_value,
   output logic [SAMPLE_W-1:0]   rsp_max_value,
   output logic [SAMPLE_W-1:0]   rsp_mean_value,
   output logic [SAMPLE_W-1:0]   rsp_latest_value,
   output logic [LEN_W-1:0]      rsp_stored_count,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned ADDR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int unsigned CAP     = (MAX_DEPTH < 511) ? MAX_DEPTH : 511;
   localparam len_type     CAP_LEN = LEN_W'(CAP);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff;
   len_type           window_length_ff;
   logic [ADDR_W-1:0] pos_ff;
   len_type           fill_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   len_type           issue_left_ff;
   logic              rd_vld_ff;
   sample_type        lo_ff;
   sample_type        hi_ff;
   sum_type           sum_ff;
   sum_type           dvd_ff;
   logic [LEN_W:0]    rem_ff;
   logic [STEP_W-1:0] step_ff;
   sample_type        latest_ff;
   logic              rsp_valid_ff;
   sample_type        rsp_min_ff;
   sample_type        rsp_max_ff;
   sample_type        rsp_mean_ff;
   sample_type        rsp_latest_ff;
   len_type           rsp_count_ff;

   logic              req_accept;
   logic              rsp_accept;
   logic              csr_write;
   len_type           eff_len;
   logic [LEN_W:0]    fill_inc;
   len_type           fill_in;
   logic [ADDR_W-1:0] pos_in;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr_in;
   sample_type        rd_data;
   logic [LEN_W:0]    rem_sh;
   logic              quo_bit;
   logic [LEN_W:0]    rem_in;
   sum_type           dvd_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_WINDOW_LENGTH) begin
         csr_prdata = CSR_DATA_W'(window_length_ff);
      end
   end

   // window size and fill level for the incoming transaction
   always_comb begin
      if (window_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (window_length_ff > CAP_LEN) begin
         eff_len = CAP_LEN;
      end else begin
         eff_len = window_length_ff;
      end
      fill_inc = {1'b0, fill_ff} + (LEN_W+1)'(1);
      fill_in  = (fill_inc > {1'b0, eff_len}) ? eff_len : fill_inc[LEN_W-1:0];
      pos_in   = (pos_ff == LAST_ADDR) ? '0 : pos_ff + ADDR_W'(1);
   end

   // scan newest to oldest
   assign rd_en      = (state_ff == ST_SCAN) && (issue_left_ff != '0);
   assign rd_addr_in = (rd_addr_ff == '0) ? LAST_ADDR : rd_addr_ff - ADDR_W'(1);

   // restoring divide step
   always_comb begin
      rem_sh  = {rem_ff[LEN_W-1:0], dvd_ff[SUM_W-1]};
      quo_bit = (rem_sh >= {1'b0, fill_ff});
      rem_in  = quo_bit ? rem_sh - {1'b0, fill_ff} : rem_sh;
      dvd_in  = {dvd_ff[SUM_W-2:0], quo_bit};
   end

   wmm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (pos_ff),
      .wr_data (req_sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         window_length_ff <= WINDOW_LENGTH_RESET;
         pos_ff           <= '0;
         fill_ff          <= '0;
         issue_left_ff    <= '0;
         rd_vld_ff        <= 1'b0;
         step_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write && (csr_paddr[2] == REG_WINDOW_LENGTH)) begin
            window_length_ff <= csr_pwdata[LEN_W-1:0];
         end
         if (rsp_accept && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               rd_vld_ff <= 1'b0;
               if (req_accept) begin
                  pos_ff        <= pos_in;
                  fill_ff       <= fill_in;
                  issue_left_ff <= fill_in;
                  rd_addr_ff    <= pos_ff;
                  latest_ff     <= req_sample;
                  lo_ff         <= '1;
                  hi_ff         <= '0;
                  sum_ff        <= '0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_vld_ff <= rd_en;
               if (rd_en) begin
                  rd_addr_ff    <= rd_addr_in;
                  issue_left_ff <= issue_left_ff - LEN_W'(1);
               end
               if (rd_vld_ff) begin
                  if (rd_data < lo_ff) begin
                     lo_ff <= rd_data;
                  end
                  if (rd_data > hi_ff) begin
                     hi_ff <= rd_data;
                  end
                  sum_ff <= sum_ff + SUM_W'(rd_data);
               end
               if (!rd_en && !rd_vld_ff) begin
                  dvd_ff   <= sum_ff;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rd_vld_ff <= 1'b0;
               dvd_ff    <= dvd_in;
               rem_ff    <= rem_in;
               step_ff   <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               rd_vld_ff <= 1'b0;
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_min_ff    <= lo_ff;
                  rsp_max_ff    <= hi_ff;
                  rsp_mean_ff   <= dvd_ff[SAMPLE_W-1:0];
                  rsp_latest_ff <= latest_ff;
                  rsp_count_ff  <= fill_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_value    = rsp_min_ff;
   assign rsp_max_value    = rsp_max_ff;
   assign rsp_mean_value   = rsp_mean_ff;
   assign rsp_latest_value = rsp_latest_ff;
   assign rsp_stored_count = rsp_count_ff;

endmodule

@@ design/wmm_ram.sv @@
`timescale 1ns / 1ps

module wmm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
